// File: rtl/rhpm_pkg.sv
// ----------------------------------------------------------------------------
// rhpm_pkg
// Shared constants, types and helpers of the random history pixel mixer.
// ----------------------------------------------------------------------------
package rhpm_pkg;

  localparam int unsigned PLANES      = 16;
  localparam int unsigned MAX_LUMA    = 65536;
  localparam int unsigned PLANE_DEPTH = MAX_LUMA + (MAX_LUMA / 2);
  localparam int unsigned MEM_DEPTH   = PLANES * PLANE_DEPTH;

  localparam int unsigned PLANE_W  = $clog2(PLANES);
  localparam int unsigned POS_W    = $clog2(PLANE_DEPTH);
  localparam int unsigned FILL_W   = $clog2(PLANE_DEPTH + 1);
  localparam int unsigned ADDR_W   = $clog2(MEM_DEPTH);
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TOL_W    = 9;
  localparam int unsigned LUMA_W   = 17;
  localparam int unsigned CMP_W    = (POS_W > LUMA_W) ? POS_W : LUMA_W;
  localparam int unsigned LCG_W    = 32;
  localparam int unsigned PICK_LSB = 24;

  localparam logic [LCG_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [LCG_W-1:0] LCG_ADD = 32'd12345;

  // apb register map
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;
  localparam logic        REG_TOL  = 1'b0;
  localparam logic        REG_LUMA = 1'b1;

  localparam logic [TOL_W-1:0]  TOL_RESET  = '0;
  localparam logic [LUMA_W-1:0] LUMA_RESET = 17'd65536;

  localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(PLANE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] PLANE_SPAN = ADDR_W'(PLANE_DEPTH);

  // side information of a word that waits for its history read
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
    logic                       luma;
    logic                       same_plane;
    logic                       hit;
  } rhpm_info_t;

  function automatic logic [ADDR_W-1:0] plane_base(input logic [PLANE_W-1:0] plane);
    plane_base = ADDR_W'(plane) * PLANE_SPAN;
  endfunction

endpackage

// File: rtl/rhpm_ram.sv
// ----------------------------------------------------------------------------
// rhpm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rhpm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/rhpm_cfg.sv
// ----------------------------------------------------------------------------
// rhpm_cfg
// APB register block: tolerance and luma sample count.
// ----------------------------------------------------------------------------
module rhpm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rhpm_pkg::PADDR_W-1:0] paddr,
  input  logic [rhpm_pkg::PDATA_W-1:0] pwdata,
  output logic [rhpm_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output logic [rhpm_pkg::TOL_W-1:0]   tolerance_o,
  output logic [rhpm_pkg::LUMA_W-1:0]  luma_samples_o
);
  import rhpm_pkg::*;

  logic               wr_en;
  logic [TOL_W-1:0]   tol_q;
  logic [LUMA_W-1:0]  luma_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q  <= TOL_RESET;
      luma_q <= LUMA_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_TOL:  tol_q  <= pwdata[TOL_W-1:0];
        REG_LUMA: luma_q <= pwdata[LUMA_W-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TOL:  prdata = PDATA_W'(tol_q);
      REG_LUMA: prdata = PDATA_W'(luma_q);
      default:  prdata = '0;
    endcase
  end

  assign tolerance_o    = tol_q;
  assign luma_samples_o = luma_q;

endmodule

// File: rtl/rhpm_front.sv
// ----------------------------------------------------------------------------
// rhpm_front
// Frame position, plane counter, random generator and history addressing.
// ----------------------------------------------------------------------------
module rhpm_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic signed [rhpm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                frame_end_i,
  input  logic [rhpm_pkg::LUMA_W-1:0]         luma_samples_i,
  output logic                                we_o,
  output logic [rhpm_pkg::ADDR_W-1:0]         waddr_o,
  output logic [rhpm_pkg::SAMPLE_W-1:0]       wdata_o,
  output logic                                re_o,
  output logic [rhpm_pkg::ADDR_W-1:0]         raddr_o,
  output rhpm_pkg::rhpm_info_t                info_o
);
  import rhpm_pkg::*;

  logic [POS_W-1:0]   pos_q, pos_d;
  logic [PLANE_W-1:0] plane_q, plane_d;
  logic [LCG_W-1:0]   lcg_q, lcg_d;
  logic [FILL_W-1:0]  fill_q [PLANES];
  logic [FILL_W-1:0]  pos_next;
  logic [PLANE_W-1:0] pick;
  rhpm_info_t         info_q, info_d;

  // lcg_q already holds the advanced value used by the next word
  assign pick     = plane_q + lcg_q[PICK_LSB +: PLANE_W];
  assign pos_next = FILL_W'(pos_q) + FILL_W'(1);

  always_comb begin
    lcg_d = lcg_q * LCG_MUL + LCG_ADD;
    if (frame_end_i) begin
      pos_d   = '0;
      plane_d = plane_q - PLANE_W'(1);
    end else begin
      pos_d   = (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
      plane_d = plane_q;
    end
  end

  always_comb begin
    info_d.sample     = sample_i;
    info_d.frame_end  = frame_end_i;
    info_d.luma       = CMP_W'(pos_q) < CMP_W'(luma_samples_i);
    info_d.same_plane = (pick == plane_q);
    // entries past the fill mark of a plane were never written and read as zero
    info_d.hit        = FILL_W'(pos_q) < fill_q[pick];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      plane_q <= PLANE_W'(PLANES - 1);
      lcg_q   <= LCG_ADD;
      for (int i = 0; i < PLANES; i++) begin
        fill_q[i] <= '0;
      end
    end else if (accept_i) begin
      pos_q   <= pos_d;
      plane_q <= plane_d;
      lcg_q   <= lcg_d;
      if (pos_next > fill_q[plane_q]) begin
        fill_q[plane_q] <= pos_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      info_q <= info_d;
    end
  end

  assign we_o    = accept_i;
  assign waddr_o = plane_base(plane_q) + ADDR_W'(pos_q);
  assign wdata_o = sample_i;
  assign re_o    = accept_i;
  assign raddr_o = plane_base(pick) + ADDR_W'(pos_q);
  assign info_o  = info_q;

endmodule

// File: rtl/rhpm_mix.sv
// ----------------------------------------------------------------------------
// rhpm_mix
// Scales the history difference, applies the tolerance, registers the word.
// ----------------------------------------------------------------------------
module rhpm_mix (
  input  logic                                 clk_i,
  input  logic                                 load_i,
  input  rhpm_pkg::rhpm_info_t                 info_i,
  input  logic [rhpm_pkg::SAMPLE_W-1:0]        rdata_i,
  input  logic [rhpm_pkg::TOL_W-1:0]           tolerance_i,
  output logic signed [rhpm_pkg::SAMPLE_W-1:0] pixel_out_o,
  output logic                                 last_o
);
  import rhpm_pkg::*;

  localparam int unsigned DIFF_W = SAMPLE_W + 1;
  localparam int unsigned SCL_W  = SAMPLE_W + 2;

  logic signed [SAMPLE_W-1:0] stored;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [SCL_W-1:0]    scaled;
  logic        [SCL_W-1:0]    mag;
  logic signed [SAMPLE_W-1:0] pixel_q, pixel_d;
  logic                       last_q;

  always_comb begin
    // same plane: the history entry is the word itself, written when it was accepted
    if (info_i.same_plane) begin
      stored = info_i.sample;
    end else if (info_i.hit) begin
      stored = signed'(rdata_i);
    end else begin
      stored = '0;
    end
    diff = DIFF_W'(stored) - DIFF_W'(info_i.sample);
    if (info_i.luma) begin
      scaled = SCL_W'(diff >>> 7);
    end else begin
      scaled = SCL_W'(diff >>> 8) + SCL_W'(128);
    end
    mag     = scaled[SCL_W-1] ? unsigned'(-scaled) : unsigned'(scaled);
    pixel_d = (mag > SCL_W'(tolerance_i)) ? stored : info_i.sample;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pixel_q <= pixel_d;
      last_q  <= info_i.frame_end;
    end
  end

  assign pixel_out_o = pixel_q;
  assign last_o      = last_q;

endmodule

// File: rtl/random_history_pixel_mixer_unit.sv
// ----------------------------------------------------------------------------
// random_history_pixel_mixer_unit
// Mixes each video sample with a randomly chosen past frame from history.
// ----------------------------------------------------------------------------
// an accepted word passes the history read and side information registers, then the mix output register
// throughput: one word per cycle, set by the single write and read port pair
//   of the history RAM; stalls only when the output is held
// reset: counters and generator clear at once; the history RAM is not swept,
//   per-plane fill marks make never-written entries read as zero
module random_history_pixel_mixer_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [rhpm_pkg::PADDR_W-1:0]         paddr,
  input  logic [rhpm_pkg::PDATA_W-1:0]         pwdata,
  output logic [rhpm_pkg::PDATA_W-1:0]         prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [rhpm_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                 frame_end_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rhpm_pkg::SAMPLE_W-1:0] pixel_out_o,
  output logic                                 last_o
);
  import rhpm_pkg::*;

  logic [TOL_W-1:0]    tolerance;
  logic [LUMA_W-1:0]   luma_samples;
  logic                we, re;
  logic [ADDR_W-1:0]   waddr, raddr;
  logic [SAMPLE_W-1:0] wdata, rdata;
  rhpm_info_t          info;

  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic out_load, s1_free, in_accept;

  assign out_load  = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_free   = !s1_valid_q || out_load;
  assign in_accept = in_valid_i && s1_free;

  always_comb begin
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (out_load) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !s1_free;
  assign out_valid_o = out_valid_q;

  rhpm_cfg u_cfg (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .tolerance_o    (tolerance),
    .luma_samples_o (luma_samples)
  );

  rhpm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .sample_i       (sample_i),
    .frame_end_i    (frame_end_i),
    .luma_samples_i (luma_samples),
    .we_o           (we),
    .waddr_o        (waddr),
    .wdata_o        (wdata),
    .re_o           (re),
    .raddr_o        (raddr),
    .info_o         (info)
  );

  rhpm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MEM_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rhpm_mix u_mix (
    .clk_i       (clk_i),
    .load_i      (out_load),
    .info_i      (info),
    .rdata_i     (rdata),
    .tolerance_i (tolerance),
    .pixel_out_o (pixel_out_o),
    .last_o      (last_o)
  );

endmodule
